// ===== sv/cwg_pkg.sv =====
// Shared types and constants for the cosine window generator.
// No dependencies.
package cwg_pkg;

   localparam int COEF_W   = 18;
   localparam int SAMPLE_W = 20;
   localparam int IDX_W    = 16;
   localparam int CFG_W    = 18;
   localparam int CFG_IDX_W = 3;
   localparam int STEPS    = 24;
   localparam int STEP_W   = 5;
   localparam int NUM_REG_COEFS = 4;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_SYMMETRIC = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_COEF0 = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_COEF1 = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_COEF2 = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_COEF3 = 3'd5;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 20'sd524287;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -20'sd524288;

   // arctangent of 2^-j in 2^-32 turn units
   function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] j);
      logic [31:0] r;
      unique case (j)
         5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
         5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
         5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
         5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
         5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
         5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
         5'd20: r = 32'd652;       5'd21: r = 32'd326;
         5'd22: r = 32'd163;       5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/cwg_req_if.sv =====
// Request and response channel interfaces for the window generator.
// Depends on cwg_pkg.
interface cwg_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface cwg_rsp_if import cwg_pkg::*; ;
   logic valid;
   logic ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic [IDX_W-1:0] sample_index;
   logic last;
   modport source (output valid, output sample, output sample_index, output last,
                   input ready);
   modport sink (input valid, input sample, input sample_index, input last,
                 output ready);
endinterface

// ===== sv/cwg_divider.sv =====
// Restoring divider: quotient = floor(p * 2^32 / m), one bit per cycle.
// Depends on cwg_pkg (for nothing but style consistency).
module cwg_divider import cwg_pkg::*; #(
   parameter int LEN_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [LEN_BITS:0]   numer,
   input  logic [LEN_BITS:0]   denom,
   output logic                done,
   output logic [31:0]         quot
);
   logic [LEN_BITS+1:0] rem_ff, rem_in;
   logic [31:0] q_ff, q_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [LEN_BITS+1:0] trial;

   always_comb begin
      rem_in = rem_ff; q_in = q_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[LEN_BITS:0], 1'b0};
      if (start) begin
         rem_in = {1'b0, numer}; q_in = '0; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, denom}) begin
            rem_in = trial - {1'b0, denom}; q_in = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = trial; q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; q_ff <= q_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ===== sv/cwg_cordic.sv =====
// Iterative CORDIC cosine in Q30, one rotation step per cycle.
// Depends on cwg_pkg for the arctangent table and gain.
module cwg_cordic import cwg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        phase,
   output logic               done,
   output logic signed [31:0] cosine
);
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [STEP_W-1:0] j_ff, j_in;
   logic [31:0] tt;
   logic signed [33:0] a, dx, dy, at;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; neg_in = neg_ff;
      j_in = j_ff; busy_in = busy_ff; done_in = 1'b0;
      a = {{2{phase[31]}}, phase};
      tt = phase;
      dx = y_ff >>> j_ff;
      dy = x_ff >>> j_ff;
      at = {2'b00, atan_turn(j_ff)};
      if (start) begin
         neg_in = 1'b0;
         if (a > 34'sh040000000 || a < -34'sh040000000) begin
            tt = phase ^ 32'h80000000; neg_in = 1'b1;
         end
         z_in = {{2{tt[31]}}, tt};
         x_in = CORDIC_GAIN; y_in = '0; j_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + at;
         end
         j_in = j_ff + 5'd1;
         if (j_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; neg_ff <= neg_in; j_ff <= j_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign cosine = neg_ff ? 32'(-x_ff) : x_ff[31:0];
endmodule

// ===== sv/cosine_window_generator_unit.sv =====
// Cosine window generator: top level, sequencer, registers and accumulator.
// Depends on cwg_pkg, cwg_req_if/cwg_rsp_if, cwg_divider, cwg_cordic.
//
// Usage: each request (restart bit) produces one window sample on the rsp
// channel, unless the window length is zero, in which case nothing comes out.
// The csr_ port writes length, mode and four Q2.16 coefficients; the user
// must write them only while idle, as the block itself does not enforce it.
// Per sample, every harmonic (the constant term included) takes a setup
// step, bit-serial phase division, CORDIC and one 18x32 multiply-add.
// A length of one answers straight from the output state, without the
// harmonic steps; a length of zero takes the request and answers nothing.
// The divider and CORDIC units are shared by all harmonics.
// One request is in flight at a time; req_ready is low meanwhile.
// The finished sample waits in an output register; a stalled receiver holds
// the block until it is taken.
// Reset restores the default registers (Hann, length 64, symmetric) and sets
// the position to zero.
module cosine_window_generator_unit import cwg_pkg::*; #(
   parameter int NUM_COEFFS = 4,
   parameter int LEN_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   cwg_req_if.sink              req,
   cwg_rsp_if.source            rsp,
   input  logic                 csr_write_enable,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data
);
   localparam int CI_W = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_TERM = 6'b000010, S_DIV = 6'b000100,
      S_COS = 6'b001000, S_MAC = 6'b010000, S_OUT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [LEN_BITS-1:0] len_ff, pos_ff, pos_in, k_ff, k_in;
   logic sym_ff;
   logic signed [COEF_W-1:0] coef_ff [NUM_REG_COEFS];
   logic [CI_W-1:0] ci_ff, ci_in;
   logic [LEN_BITS:0] p_ff, p_in, m_ff, m_in;
   logic signed [52:0] acc_ff, acc_in;
   logic signed [49:0] prod_ff;
   logic signed [SAMPLE_W-1:0] samp_ff, samp_in;
   logic last_ff, last_in;
   logic div_start, div_done, cos_start, cos_done;
   logic [31:0] quot;
   logic signed [31:0] cosv;
   logic [31:0] phase;
   logic [LEN_BITS+1:0] psum;
   logic signed [52:0] rnd;
   logic signed [COEF_W-1:0] cur_coef;
   logic [LEN_BITS-1:0] kk;
   logic [LEN_BITS:0] ncur;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_BITS'(64); sym_ff <= 1'b1;
         coef_ff[0] <= 18'sd32768; coef_ff[1] <= 18'sd32768;
         coef_ff[2] <= '0; coef_ff[3] <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_LENGTH:    len_ff <= LEN_BITS'(csr_write_data[15:0]);
            REG_SYMMETRIC: sym_ff <= csr_write_data[0];
            REG_COEF0:     coef_ff[0] <= csr_write_data;
            REG_COEF1:     coef_ff[1] <= csr_write_data;
            REG_COEF2:     coef_ff[2] <= csr_write_data;
            REG_COEF3:     coef_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign cur_coef = (int'(ci_ff) < NUM_REG_COEFS) ? coef_ff[2'(ci_ff)] : '0;
   assign psum = {1'b0, p_ff} + {1'b0, k_ff};
   assign phase = ci_ff[0] ? quot + 32'h80000000 : quot;
   assign rnd = acc_ff + 53'sd536870912;
   assign ncur = {1'b0, len_ff} - {{LEN_BITS{1'b0}}, sym_ff};
   assign kk = (req.restart || pos_ff >= len_ff) ? '0 : pos_ff;

   // sequencer
   always_comb begin
      state_in = state_ff; pos_in = pos_ff; k_in = k_ff; ci_in = ci_ff;
      p_in = p_ff; m_in = m_ff; acc_in = acc_ff; samp_in = samp_ff;
      last_in = last_ff; div_start = 1'b0; cos_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               if (req.restart) pos_in = '0;
               if (len_ff != '0) begin
                  k_in = kk;
                  last_in = (kk == len_ff - 1'b1);
                  pos_in = last_in ? '0 : kk + 1'b1;
                  m_in = ncur;
                  ci_in = '0; p_in = '0;
                  acc_in = '0;
                  if (len_ff == LEN_BITS'(1)) begin
                     acc_in = 53'sd65536 <<< 30; state_in = S_OUT;
                  end else begin
                     state_in = S_TERM;
                  end
               end
            end
         end
         S_TERM: begin
            // phase division for the current harmonic
            div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               cos_start = 1'b1; state_in = S_COS;
            end
         end
         S_COS: begin
            if (cos_done) state_in = S_MAC;
         end
         S_MAC: begin
            acc_in = acc_ff + 53'(prod_ff);
            if (int'(ci_ff) == NUM_COEFFS - 1) begin
               state_in = S_OUT;
            end else begin
               // advance p = i*k mod m
               ci_in = ci_ff + 1'b1;
               p_in = (psum >= {1'b0, m_ff}) ? (LEN_BITS+1)'(psum - {1'b0, m_ff})
                                             : psum[LEN_BITS:0];
               state_in = S_TERM;
            end
         end
         S_OUT: begin
            if ($signed(rnd[52:30]) > 23'sd524287) samp_in = SAMPLE_MAX;
            else if ($signed(rnd[52:30]) < -23'sd524288) samp_in = SAMPLE_MIN;
            else samp_in = rnd[49:30];
            if (rsp.ready || !rsp.valid) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   logic vld_ff;
   always_ff @(posedge clock) begin
      k_ff <= k_in; ci_ff <= ci_in; p_ff <= p_in; m_ff <= m_in;
      acc_ff <= acc_in; last_ff <= last_in;
      prod_ff <= cur_coef * cosv;
      if (reset) begin
         state_ff <= S_IDLE; pos_ff <= '0; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pos_ff <= pos_in;
         if (state_ff == S_OUT && (rsp.ready || !vld_ff)) begin
            vld_ff <= 1'b1;
         end else if (rsp.ready) begin
            vld_ff <= 1'b0;
         end
      end
   end

   // output register
   logic signed [SAMPLE_W-1:0] osamp_ff;
   logic [IDX_W-1:0] oidx_ff;
   logic olast_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && (rsp.ready || !vld_ff)) begin
         osamp_ff <= samp_in; oidx_ff <= IDX_W'(k_ff); olast_ff <= last_ff;
      end
      samp_ff <= samp_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = vld_ff;
   assign rsp.sample = osamp_ff;
   assign rsp.sample_index = oidx_ff;
   assign rsp.last = olast_ff;

   cwg_divider #(.LEN_BITS(LEN_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(p_in),
      .denom(m_ff), .done(div_done), .quot(quot)
   );

   cwg_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cos_start), .phase(phase),
      .done(cos_done), .cosine(cosv)
   );

   // a request is only taken when nothing is in flight
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == S_IDLE || state_ff == S_TERM ||
                                    state_ff == S_OUT))
      else $error("unexpected state after request");
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside its phase");
   assert property (@(posedge clock) disable iff (reset)
      cos_done |-> state_ff == S_COS)
      else $error("cordic finished outside its phase");
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid)
      else $error("result dropped under stall");
endmodule

// ===== dv/tb_cosine_window_generator_unit.sv =====
// Self-checking testbench for cosine_window_generator_unit: random and directed
// requests, a bit-exact sample predictor and an in-order response checker.
// Depends on cwg_pkg, cwg_req_if, cwg_rsp_if and the unit's RTL.
module tb_cosine_window_generator_unit;
   import cwg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic [IDX_W-1:0]           sample_index;
      logic                       last;
   } window_sample_type;

   localparam longint ATAN_TURNS [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};
   localparam int SETTLE_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CFG_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_write_data = '0;

   cwg_req_if req_ch ();
   cwg_rsp_if rsp_ch ();

   cosine_window_generator_unit u_top (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data));

   always #6 clock = ~clock;

   // mirrored registers and position
   longint unsigned win_len = 64;
   bit win_symmetric = 1'b1;
   longint win_coef [4] = '{32768, 32768, 0, 0};
   longint unsigned win_pos = 0;

   bit restart_pending [$];
   window_sample_type expected_samples [$];
   int mismatches = 0;
   int n_requests = 0;
   int n_samples = 0;
   int n_settings = 0;
   bit quiet = 1'b0;
   bit long_hold_req = 1'b0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // cosine of a 2^-32 turn angle, Q30, by 24 CORDIC rotations
   function automatic longint cordic_cos(input logic [31:0] t);
      longint a, x, y, z, dx, dy;
      bit neg;
      neg = 1'b0;
      a = longint'(int'(t));
      if (a > 64'sh40000000 || a < -64'sh40000000) begin
         t ^= 32'h80000000;
         a = longint'(int'(t));
         neg = 1'b1;
      end
      x = 652032874;
      y = 0;
      z = a;
      for (int j = 0; j < 24; j++) begin
         dx = y >>> j;
         dy = x >>> j;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TURNS[j];
         end else begin
            x += dx; y -= dy; z += ATAN_TURNS[j];
         end
      end
      return neg ? -x : x;
   endfunction

   // advance the mirrored position for one request and queue its sample (none for a zero length)
   function automatic void predict_sample(input bit restart);
      longint unsigned k, m, p;
      logic [31:0] t;
      longint acc, s;
      window_sample_type e;
      if (restart) win_pos = 0;
      if (win_len == 0) return;
      if (win_pos >= win_len) win_pos = 0;
      k = win_pos;
      if (win_len == 1) begin
         s = 65536;
      end else begin
         m = (win_symmetric ? win_len : win_len + 1) - 1;
         acc = 0;
         for (int i = 0; i < 4; i++) begin
            p = (longint'(i) * k) % m;
            t = 32'((p << 32) / m);
            if (i % 2 == 1) t += 32'h80000000;
            acc += win_coef[i] * cordic_cos(t);
         end
         s = (acc + (64'sd1 << 29)) >>> 30;
         if (s > 524287) s = 524287;
         if (s < -524288) s = -524288;
      end
      e.sample = s[SAMPLE_W-1:0];
      e.sample_index = k[IDX_W-1:0];
      e.last = (k == win_len - 1);
      expected_samples.push_back(e);
      win_pos = (k == win_len - 1) ? 0 : ((k + 1) & 64'hFFFF);
   endfunction

   // request driver
   bit offering = 1'b0;
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.restart <= 1'b0;
         offering = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_sample(restart_pending.pop_front());
            n_requests++;
            offering = 1'b0;
            if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 12);
         end
         if (!offering) begin
            if (send_gap > 0) send_gap--;
            else if (restart_pending.size() > 0) begin
               offering = 1'b1;
               req_ch.restart <= restart_pending[0];
            end
         end
         req_ch.valid <= offering;
      end
   end

   // response monitor with random back-pressure
   int rsp_stall = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected sample", rsp_ch.sample, 0);
            end else begin
               window_sample_type e;
               e = expected_samples.pop_front();
               n_samples++;
               if (rsp_ch.sample !== e.sample)
                  report_mismatch("sample", rsp_ch.sample, e.sample);
               if (rsp_ch.sample_index !== e.sample_index)
                  report_mismatch("sample_index", rsp_ch.sample_index, e.sample_index);
               if (rsp_ch.last !== e.last)
                  report_mismatch("last", rsp_ch.last, e.last);
            end
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall = 600;
         end else if (rsp_stall > 0) rsp_stall--;
         else if (!quiet && $urandom_range(0, 7) == 0) rsp_stall = $urandom_range(1, 12);
         rsp_ch.ready <= (rsp_stall == 0);
      end
   end

   task automatic csr_write(input logic [CFG_IDX_W-1:0] idx, input longint value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[CFG_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // program all registers, then mirror them
   task automatic load_window(input longint unsigned len, input bit sym,
                              input longint c0, input longint c1,
                              input longint c2, input longint c3);
      csr_write(REG_LENGTH, len);
      csr_write(REG_SYMMETRIC, sym);
      csr_write(REG_COEF0, c0);
      csr_write(REG_COEF1, c1);
      csr_write(REG_COEF2, c2);
      csr_write(REG_COEF3, c3);
      win_len = len;
      win_symmetric = sym;
      win_coef = '{c0, c1, c2, c3};
      n_settings++;
   endtask

   task automatic send_requests(input int count, input int restart_odds);
      for (int i = 0; i < count; i++)
         restart_pending.push_back($urandom_range(0, restart_odds) == 0);
   endtask

   task automatic drain;
      while (restart_pending.size() > 0 || offering || expected_samples.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic longint random_coef;
      case ($urandom_range(0, 5))
         0: return 131071;
         1: return -131072;
         2: return 0;
         default: return longint'($urandom_range(0, 262143)) - 131072;
      endcase
   endfunction

   initial begin
      req_ch.valid = 1'b0;
      req_ch.restart = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults (Hann 64), then edge lengths and modes
      send_requests(4, 1);
      drain();
      load_window(0, 1, 32768, 32768, 0, 0);
      send_requests(2, 1);
      drain();
      load_window(1, 0, -131072, 131071, 5, 7);
      send_requests(2, 1);
      drain();
      load_window(2, 1, 131071, 131071, 131071, 131071);
      send_requests(3, 100);
      drain();
      load_window(3, 0, -131072, -131072, -131072, -131072);
      send_requests(3, 100);
      drain();
      // stale position: shrink the window mid-run
      load_window(20, 1, 35389, 30147, 0, 0);
      send_requests(6, 1000);
      drain();
      load_window(4, 0, 27439, 32768, 5329, 0);
      send_requests(2, 1000);
      drain();
      load_window(65535, 0, 65536, -65536, 65536, -65536);
      send_requests(3, 1);
      drain();

      // random windows; one long receiver hold fills the pipe
      for (int ph = 0; ph < 40; ph++) begin
         longint unsigned len;
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 48);
         // the long hold needs a window that produces samples
         if (ph == 5 && len == 0) len = 8;
         if (ph == 39) quiet = 1'b1;
         load_window(len, $urandom_range(0, 1), random_coef(), random_coef(),
                     random_coef(), random_coef());
         if (ph == 5) long_hold_req = 1'b1;
         send_requests($urandom_range(20, 44), 12);
         drain();
      end

      $display("Covered %0d requests and %0d samples over %0d register settings,",
               n_requests, n_samples, n_settings);
      $display("including zero/one lengths, both modes, saturation and restarts.");
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #40ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/cwg_pkg.sv
sv/cwg_req_if.sv
sv/cwg_divider.sv
sv/cwg_cordic.sv
sv/cosine_window_generator_unit.sv
dv/tb_cosine_window_generator_unit.sv
